FILE: rtl/fsp_pkg.sv
package fsp_pkg;

  // Width of the decimal accumulators; values saturate at 2^COUNT_BITS - 1
  localparam int COUNT_BITS = 16;
  // Width of the width and precision fields in a result word
  localparam int FIELD_BITS = 16;
  localparam int WIDE_BITS  = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
  localparam int ACC_BITS   = COUNT_BITS + 4;

  typedef enum logic [2:0] {
    PH_FLAGS = 3'd0,
    PH_WDIG  = 3'd1,
    PH_WDONE = 3'd2,
    PH_DOT   = 3'd3,
    PH_PDIG  = 3'd4,
    PH_PDONE = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    CONV_NONE = 4'd0,
    CONV_S    = 4'd1,
    CONV_PCT  = 4'd2,
    CONV_C    = 4'd3,
    CONV_D    = 4'd4,
    CONV_I    = 4'd5,
    CONV_U    = 4'd6,
    CONV_P    = 4'd7,
    CONV_X    = 4'd8,
    CONV_XU   = 4'd9
  } conv_t;

  // Flag bit positions
  localparam int FLAG_MINUS = 0;
  localparam int FLAG_PLUS  = 1;
  localparam int FLAG_SPACE = 2;
  localparam int FLAG_HASH  = 3;
  localparam int FLAG_ZERO  = 4;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;

  typedef struct packed {
    phase_t                phase;
    logic [4:0]            flag_bits;
    logic [COUNT_BITS-1:0] width_count;
    logic                  width_star;
    logic [COUNT_BITS-1:0] precision_count;
    logic                  precision_seen;
    logic                  precision_star;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:           PH_FLAGS,
    flag_bits:       5'd0,
    width_count:     '0,
    width_star:      1'b0,
    precision_count: '0,
    precision_seen:  1'b0,
    precision_star:  1'b0
  };

  typedef struct packed {
    logic                  final_consumed;
    conv_t                 conversion;
    logic                  precision_from_argument;
    logic                  precision_given;
    logic [FIELD_BITS-1:0] precision_value;
    logic                  width_from_argument;
    logic [FIELD_BITS-1:0] min_width;
    logic                  zero_pad;
    logic                  alternate_form;
    logic                  space_sign;
    logic                  force_sign;
    logic                  pad_right;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);
  localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

  function automatic conv_t conv_code(input logic [7:0] c);
    conv_t r;
    case (c)
      CH_S:    r = CONV_S;
      CH_PCT:  r = CONV_PCT;
      CH_C:    r = CONV_C;
      CH_D:    r = CONV_D;
      CH_I:    r = CONV_I;
      CH_U:    r = CONV_U;
      CH_P:    r = CONV_P;
      CH_X:    r = CONV_X;
      CH_XU:   r = CONV_XU;
      default: r = CONV_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] flag_bit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c)
      CH_MINUS: r[FLAG_MINUS] = 1'b1;
      CH_PLUS:  r[FLAG_PLUS]  = 1'b1;
      CH_SPACE: r[FLAG_SPACE] = 1'b1;
      CH_HASH:  r[FLAG_HASH]  = 1'b1;
      CH_ZERO:  r[FLAG_ZERO]  = 1'b1;
      default:  r = 5'd0;
    endcase
    return r;
  endfunction

  // acc * 10 + digit, saturating at the counter maximum
  function automatic logic [COUNT_BITS-1:0] accumulate(
    input logic [COUNT_BITS-1:0] acc,
    input logic [3:0]            digit
  );
    logic [ACC_BITS-1:0] wide;
    logic [ACC_BITS-1:0] sum;
    wide = ACC_BITS'(acc);
    sum  = (wide << 3) + (wide << 1) + ACC_BITS'(digit);
    if (sum > ACC_BITS'({COUNT_BITS{1'b1}})) begin
      return {COUNT_BITS{1'b1}};
    end
    return sum[COUNT_BITS-1:0];
  endfunction

  // Low FIELD_BITS of a counter, zero extended if the counter is narrower
  function automatic logic [FIELD_BITS-1:0] to_field(input logic [COUNT_BITS-1:0] c);
    logic [WIDE_BITS-1:0] w;
    w = WIDE_BITS'(c);
    return w[FIELD_BITS-1:0];
  endfunction

endpackage

FILE: rtl/format_specifier_parser.sv
// Format specifier parser.
// Feed the bytes that follow a percent sign on the s_axis channel, one byte
// per word: s_axis_tdata is the byte, s_axis_tuser set marks the first byte
// of a new specifier and clears any parse in progress. Flags, width,
// precision and conversion are collected; the byte that ends the specifier
// (a conversion character, or any byte that cannot continue it) makes one
// result word on m_axis. Bytes that continue the specifier make no word.
// The result word for the ending byte is registered in the output register,
// or in the skid register while the receiver stalls. Throughput: one byte
// per cycle while s_axis_tready is high, set by the single phase update and
// times-ten accumulate between the parse state register and the output
// register. When the receiver stalls, the output register holds its word and
// a skid register takes one more; s_axis_tready drops only while the skid
// register is full. Reset clears the parse state to the flags phase and
// empties both output registers.
module format_specifier_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] char_in
  input  logic                           s_axis_tuser,  // [0] begin_req
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] pad_right (minus flag), [1] force_sign, [2] space_sign,
  // [3] alternate_form, [4] zero_pad, [20:5] min_width,
  // [21] width_from_argument, [37:22] precision_value, [38] precision_given,
  // [39] precision_from_argument, [43:40] conversion, [44] final_consumed,
  // upper bits zero
  output logic [fsp_pkg::TDATA_BITS-1:0] m_axis_tdata
);

  fsp_pkg::parse_state_t st;
  fsp_pkg::parse_state_t st_next;
  logic                  emit;
  fsp_pkg::result_t      res;
  fsp_pkg::result_t      out_res;
  logic                  accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  fsp_parse u_parse (
    .st        (st),
    .char_in   (s_axis_tdata),
    .begin_req (s_axis_tuser),
    .st_next   (st_next),
    .emit      (emit),
    .res       (res)
  );

  // Advance the parse state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= fsp_pkg::STATE_CLEAR;
    end else if (accept) begin
      st <= st_next;
    end
  end

  fsp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && emit),
    .in_ready  (s_axis_tready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = fsp_pkg::TDATA_BITS'(out_res);

endmodule

FILE: rtl/fsp_parse.sv
module fsp_parse (
  input  fsp_pkg::parse_state_t st,
  input  logic [7:0]            char_in,
  input  logic                  begin_req,
  output fsp_pkg::parse_state_t st_next,
  output logic                  emit,
  output fsp_pkg::result_t      res
);

  fsp_pkg::parse_state_t cur;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [4:0]            fbit;
  fsp_pkg::conv_t        conv;
  logic                  handled;
  logic                  early_phase;

  assign is_digit = (char_in >= fsp_pkg::CH_ZERO) && (char_in <= fsp_pkg::CH_NINE);
  assign digit    = char_in[3:0];
  assign fbit     = fsp_pkg::flag_bit(char_in);
  assign conv     = fsp_pkg::conv_code(char_in);

  // Advance the parse by one byte
  always_comb begin
    cur         = begin_req ? fsp_pkg::STATE_CLEAR : st;
    st_next     = cur;
    handled     = 1'b0;
    early_phase = (cur.phase == fsp_pkg::PH_FLAGS) || (cur.phase == fsp_pkg::PH_WDIG) ||
                  (cur.phase == fsp_pkg::PH_WDONE);
    case (cur.phase)
      fsp_pkg::PH_FLAGS: begin
        if (fbit != 5'd0) begin
          st_next.flag_bits = cur.flag_bits | fbit;
          handled = 1'b1;
        end else if (char_in == fsp_pkg::CH_STAR) begin
          st_next.width_star = 1'b1;
          st_next.phase      = fsp_pkg::PH_WDONE;
          handled = 1'b1;
        end else if (is_digit) begin
          st_next.width_count = fsp_pkg::accumulate('0, digit);
          st_next.phase       = fsp_pkg::PH_WDIG;
          handled = 1'b1;
        end
      end
      fsp_pkg::PH_WDIG: begin
        if (is_digit) begin
          st_next.width_count = fsp_pkg::accumulate(cur.width_count, digit);
          handled = 1'b1;
        end
      end
      fsp_pkg::PH_DOT: begin
        if (char_in == fsp_pkg::CH_STAR) begin
          st_next.precision_seen = 1'b0;
          st_next.precision_star = 1'b1;
          st_next.phase          = fsp_pkg::PH_PDONE;
          handled = 1'b1;
        end else if (is_digit) begin
          st_next.precision_count = fsp_pkg::accumulate('0, digit);
          st_next.phase           = fsp_pkg::PH_PDIG;
          handled = 1'b1;
        end
      end
      fsp_pkg::PH_PDIG: begin
        if (is_digit) begin
          st_next.precision_count = fsp_pkg::accumulate(cur.precision_count, digit);
          handled = 1'b1;
        end
      end
      default: begin
        handled = 1'b0;
      end
    endcase

    // A dot opens the precision while no precision has started
    if (!handled && (char_in == fsp_pkg::CH_DOT) && early_phase) begin
      st_next.precision_seen = 1'b1;
      st_next.phase          = fsp_pkg::PH_DOT;
      handled = 1'b1;
    end

    // Anything else ends the specifier
    emit = !handled;
    if (!handled) begin
      st_next = fsp_pkg::STATE_CLEAR;
    end

    res.pad_right               = cur.flag_bits[fsp_pkg::FLAG_MINUS];
    res.force_sign              = cur.flag_bits[fsp_pkg::FLAG_PLUS];
    res.space_sign              = cur.flag_bits[fsp_pkg::FLAG_SPACE];
    res.alternate_form          = cur.flag_bits[fsp_pkg::FLAG_HASH];
    res.zero_pad                = cur.flag_bits[fsp_pkg::FLAG_ZERO];
    res.min_width               = fsp_pkg::to_field(cur.width_count);
    res.width_from_argument     = cur.width_star;
    res.precision_value         = fsp_pkg::to_field(cur.precision_count);
    res.precision_given         = cur.precision_seen;
    res.precision_from_argument = cur.precision_star;
    res.conversion              = conv;
    res.final_consumed          = (conv != fsp_pkg::CONV_NONE);
  end

endmodule

FILE: rtl/fsp_out_buf.sv
module fsp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fsp_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fsp_pkg::result_t out_data
);

  logic             skid_valid;
  fsp_pkg::result_t skid_data;

  assign in_ready = !skid_valid;

  // Hold a word in the skid stage while the output register is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        out_data  <= in_data;
      end
    end else if (!out_valid) begin
      out_valid <= in_valid;
      out_data  <= in_data;
    end else if (in_valid) begin
      skid_valid <= 1'b1;
      skid_data  <= in_data;
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import fsp_pkg::*;

  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          DRAIN_CYCLES  = 20;
  localparam int          RANDOM_CHARS  = 358;
  localparam logic [63:0] COUNT_MAX     = (64'd1 << COUNT_BITS) - 64'd1;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = 8'd0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_axis_tdata;

  // Parse state of the predictor
  phase_t                spec_phase;
  logic [4:0]            spec_flags;
  logic [COUNT_BITS-1:0] spec_width;
  logic                  spec_wstar;
  logic [COUNT_BITS-1:0] spec_prec;
  logic                  spec_pseen;
  logic                  spec_pstar;

  result_t     pending_specs[$];
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int          chars_sent     = 0;
  int          send_idle_pct  = 0;
  int          recv_idle_pct  = 0;

  format_specifier_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void clear_spec();
    spec_phase = PH_FLAGS;
    spec_flags = 5'd0;
    spec_width = '0;
    spec_wstar = 1'b0;
    spec_prec  = '0;
    spec_pseen = 1'b0;
    spec_pstar = 1'b0;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  function automatic logic [4:0] flag_mask(input logic [7:0] ch);
    logic [4:0] m;
    m = 5'd0;
    if (ch == CH_MINUS) begin
      m[FLAG_MINUS] = 1'b1;
    end else if (ch == CH_PLUS) begin
      m[FLAG_PLUS] = 1'b1;
    end else if (ch == CH_SPACE) begin
      m[FLAG_SPACE] = 1'b1;
    end else if (ch == CH_HASH) begin
      m[FLAG_HASH] = 1'b1;
    end else if (ch == CH_ZERO) begin
      m[FLAG_ZERO] = 1'b1;
    end
    return m;
  endfunction

  function automatic conv_t conv_of(input logic [7:0] ch);
    case (ch)
      CH_S:    return CONV_S;
      CH_PCT:  return CONV_PCT;
      CH_C:    return CONV_C;
      CH_D:    return CONV_D;
      CH_I:    return CONV_I;
      CH_U:    return CONV_U;
      CH_P:    return CONV_P;
      CH_X:    return CONV_X;
      CH_XU:   return CONV_XU;
      default: return CONV_NONE;
    endcase
  endfunction

  // Times ten plus digit, clamped at the counter maximum
  function automatic logic [COUNT_BITS-1:0] dec_step(input logic [COUNT_BITS-1:0] acc,
                                                     input logic [7:0] ch);
    logic [63:0] v;
    v = 64'(acc) * 64'd10 + 64'(ch - CH_ZERO);
    if (v > COUNT_MAX) begin
      v = COUNT_MAX;
    end
    return v[COUNT_BITS-1:0];
  endfunction

  // Advance the predicted parse by one byte; done marks a finished specifier
  function automatic void parse_char(input logic [7:0] ch, input logic first,
                                     output logic done, output result_t res);
    logic        taken;
    logic [63:0] wide;
    conv_t       conv;
    if (first) begin
      clear_spec();
    end
    done  = 1'b0;
    taken = 1'b1;
    res   = '0;
    case (spec_phase)
      PH_FLAGS: begin
        if (flag_mask(ch) != 5'd0) begin
          spec_flags = spec_flags | flag_mask(ch);
        end else if (ch == CH_STAR) begin
          spec_wstar = 1'b1;
          spec_phase = PH_WDONE;
        end else if (is_digit(ch)) begin
          spec_width = dec_step('0, ch);
          spec_phase = PH_WDIG;
        end else begin
          taken = 1'b0;
        end
      end
      PH_WDIG: begin
        if (is_digit(ch)) begin
          spec_width = dec_step(spec_width, ch);
        end else begin
          taken = 1'b0;
        end
      end
      PH_DOT: begin
        if (ch == CH_STAR) begin
          spec_pseen = 1'b0;
          spec_pstar = 1'b1;
          spec_phase = PH_PDONE;
        end else if (is_digit(ch)) begin
          spec_prec  = dec_step('0, ch);
          spec_phase = PH_PDIG;
        end else begin
          taken = 1'b0;
        end
      end
      PH_PDIG: begin
        if (is_digit(ch)) begin
          spec_prec = dec_step(spec_prec, ch);
        end else begin
          taken = 1'b0;
        end
      end
      default: begin
        taken = 1'b0;
      end
    endcase
    if (!taken) begin
      if (ch == CH_DOT && spec_phase <= PH_WDONE) begin
        spec_pseen = 1'b1;
        spec_phase = PH_DOT;
      end else begin
        // Close the specifier and emit what was collected
        conv = conv_of(ch);
        res.pad_right               = spec_flags[FLAG_MINUS];
        res.force_sign              = spec_flags[FLAG_PLUS];
        res.space_sign              = spec_flags[FLAG_SPACE];
        res.alternate_form          = spec_flags[FLAG_HASH];
        res.zero_pad                = spec_flags[FLAG_ZERO];
        wide                        = 64'(spec_width);
        res.min_width               = wide[FIELD_BITS-1:0];
        res.width_from_argument     = spec_wstar;
        wide                        = 64'(spec_prec);
        res.precision_value         = wide[FIELD_BITS-1:0];
        res.precision_given         = spec_pseen;
        res.precision_from_argument = spec_pstar;
        res.conversion              = conv;
        res.final_consumed          = (conv != CONV_NONE);
        done                        = 1'b1;
        clear_spec();
      end
    end
  endfunction

  // Offer one byte, hold it until accepted, then predict
  task automatic send_char(input logic [7:0] ch, input logic first);
    logic    done;
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    chars_sent++;
    parse_char(ch, first, done, res);
    if (done) begin
      pending_specs.push_back(res);
    end
  endtask

  task automatic send_string(input string s, input logic first);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], (i == 0) ? first : 1'b0);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      end
    end
  endtask

  // Compare each result word with the oldest predicted specifier
  always @(posedge clk) begin : check_results
    result_t     want;
    result_t     got;
    logic [63:0] pad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[RESULT_BITS-1:0]);
      pad = 64'(m_axis_tdata >> RESULT_BITS);
      if (pending_specs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result word %h with no specifier pending", m_axis_tdata);
        end
      end else begin
        want = pending_specs.pop_front();
        check_field("pad_right", 64'(want.pad_right), 64'(got.pad_right));
        check_field("force_sign", 64'(want.force_sign), 64'(got.force_sign));
        check_field("space_sign", 64'(want.space_sign), 64'(got.space_sign));
        check_field("alternate_form", 64'(want.alternate_form),
                    64'(got.alternate_form));
        check_field("zero_pad", 64'(want.zero_pad), 64'(got.zero_pad));
        check_field("min_width", 64'(want.min_width), 64'(got.min_width));
        check_field("width_from_argument", 64'(want.width_from_argument),
                    64'(got.width_from_argument));
        check_field("precision_value", 64'(want.precision_value),
                    64'(got.precision_value));
        check_field("precision_given", 64'(want.precision_given),
                    64'(got.precision_given));
        check_field("precision_from_argument", 64'(want.precision_from_argument),
                    64'(got.precision_from_argument));
        check_field("conversion", 64'(want.conversion), 64'(got.conversion));
        check_field("final_consumed", 64'(want.final_consumed),
                    64'(got.final_consumed));
        check_field("padding", 64'd0, pad);
      end
    end
  end

  task automatic test_flags();
    send_string("-+ #0d", 1'b1);
  endtask

  task automatic test_width_saturation();
    send_string("65536u", 1'b1);
  endtask

  // Star width and precision, digit after a star, bare dot without begin
  task automatic test_star_args();
    send_string("*.*X", 1'b1);
    send_string("*5", 1'b1);
    send_string(".%", 1'b0);
  endtask

  // Flag after width, zero byte, all-ones byte
  task automatic test_unexpected_bytes();
    send_string("5-", 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b0);
  endtask

  // Begin request in the middle of a width clears it
  task automatic test_restart();
    send_string("1", 1'b1);
    send_string("c", 1'b1);
  endtask

  // Mostly well-formed specifiers with random content, some noise
  task automatic test_random(input int n_chars);
    string      flag_chars;
    string      conv_chars;
    string      odd_chars;
    logic [7:0] seq[$];
    int         stop_at;
    int         pick;
    int         n;
    stop_at    = chars_sent + n_chars;
    flag_chars = "-+ #0";
    conv_chars = "s%cdiupxX";
    odd_chars  = "-+ #0123456789*.%scdiupxX";
    while (chars_sent < stop_at) begin
      seq.delete();
      if ($urandom_range(99) < 80) begin
        repeat ($urandom_range(0, 3)) begin
          seq.push_back(flag_chars[$urandom_range(0, 4)]);
        end
        pick = $urandom_range(0, 9);
        if (pick >= 8) begin
          seq.push_back(CH_STAR);
        end else if (pick >= 4) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
          seq.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
          repeat (n - 1) begin
            seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
        end
        pick = $urandom_range(0, 9);
        if (pick >= 4) begin
          seq.push_back(CH_DOT);
          if (pick >= 8) begin
            seq.push_back(CH_STAR);
          end else if (pick >= 5) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
            repeat (n) begin
              seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
          end
        end
        if ($urandom_range(99) < 85) begin
          seq.push_back(conv_chars[$urandom_range(0, 8)]);
        end else begin
          seq.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(1)) begin
            seq.push_back(odd_chars[$urandom_range(0, odd_chars.len() - 1)]);
          end else begin
            seq.push_back(8'($urandom_range(0, 255)));
          end
        end
      end
      for (int i = 0; i < seq.size(); i++) begin
        send_char(seq[i], (i == 0) ? ($urandom_range(0, 9) != 0)
                                   : ($urandom_range(0, 29) == 0));
      end
    end
  endtask

  initial begin
    clear_spec();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 71;
    test_flags();
    test_width_saturation();
    test_star_args();
    test_unexpected_bytes();
    test_restart();
    test_random(RANDOM_CHARS);

    send_idle_pct = 71;
    recv_idle_pct = 29;
    test_random(RANDOM_CHARS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(RANDOM_CHARS);

    // Drain outstanding results
    s_axis_tvalid <= 1'b0;
    while (pending_specs.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_specs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fsp_pkg.sv
rtl/fsp_parse.sv
rtl/fsp_out_buf.sv
rtl/format_specifier_parser.sv
sim/tb.sv
